/* rtl/wc3_pkg.sv */
// ----------------------------------------------------------------------------
// wc3_pkg
// shared constants and types of the 3x3 window convolution
// ----------------------------------------------------------------------------
package wc3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = COL_W + 1;
    localparam int ROW_W       = 16;
    localparam int ROW_CNT_W   = ROW_W + 1;
    localparam int CNT_W       = 26;
    localparam int PIXEL_BITS  = 8;
    localparam int CHANNELS    = 3;
    localparam int PIX_W       = PIXEL_BITS * CHANNELS;
    localparam int COEFF_BITS  = 16;
    localparam int CFG_W       = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int PROD_W      = PIXEL_BITS + COEFF_BITS + 1;
    localparam int ACC_W       = 32;
    localparam int OUT0_W      = 29;
    localparam int OUT12_W     = 28;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 112;

    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_TOP    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_MID    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_BOTTOM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KEEP_CHAN    = 3'd5;

    localparam logic [CFG_W-1:0] COEFF_MID_RESET = 48'h0000_1000_0000;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic             right_rep;
        logic             left_rep;
        logic             top;
        logic             bot;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } meta_t;

    typedef struct packed {
        logic                      frame_end;
        logic [ROW_W-1:0]          out_row;
        logic [COL_W-1:0]          out_col;
        logic signed [OUT12_W-1:0] out2;
        logic signed [OUT12_W-1:0] out1;
        logic signed [OUT0_W-1:0]  out0;
    } result_t;

endpackage

/* rtl/window_convolution_3x3.sv */
// ----------------------------------------------------------------------------
// window_convolution_3x3
// 3x3 correlation filter with two line stores on a raster pixel stream
// path: the transaction that completes a result passes stages a, b, c, d and e, then the output stage
// throughput: one transaction per cycle while s_tready is high, set by one line store port per cycle
// stalls: a two-entry output stage lets the input run while a result waits
// reset: synchronous active low, clears counters, window and valid bits and loads configuration defaults;
// line stores are not cleared, border replication keeps them out of results
// ----------------------------------------------------------------------------
module window_convolution_3x3 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wc3_pkg::IN_TDATA_W-1:0]   s_tdata,  // chan0, chan1, chan2
    input  logic                             s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wc3_pkg::OUT_TDATA_W-1:0]  m_tdata,  // out0, out1, out2, out_col, out_row
    output logic                             m_tlast,  // frame_end
    input  logic                             cfg_wr_en,
    input  logic [wc3_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wc3_pkg::CFG_W-1:0]        cfg_wr_data
);
    import wc3_pkg::*;

    // configuration
    logic [CFG_W-1:0]     coeff_reg [3];
    logic [WID_W-1:0]     image_width_reg;
    logic [ROW_W-1:0]     image_height_reg;
    logic                 keep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg[0]     <= '0;
            coeff_reg[1]     <= COEFF_MID_RESET;
            coeff_reg[2]     <= '0;
            image_width_reg  <= WID_W'(MAX_WIDTH);
            image_height_reg <= ROW_W'(1024);
            keep_reg         <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_COEFF_TOP:    coeff_reg[0]     <= cfg_wr_data;
                REG_COEFF_MID:    coeff_reg[1]     <= cfg_wr_data;
                REG_COEFF_BOTTOM: coeff_reg[2]     <= cfg_wr_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[WID_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[ROW_W-1:0];
                REG_KEEP_CHAN:    keep_reg         <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // position control
    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [ROW_CNT_W-1:0] in_row_reg, in_row_next;
    logic [CNT_W-1:0]     emitted_reg, emitted_next;

    logic                 en;
    logic                 s_acc;
    logic [WID_W-1:0]     w_eff;
    logic [ROW_W-1:0]     h_eff;
    logic                 wrap0, wrap1, ignore, started, at_edge, last;
    logic [COL_W-1:0]     c_cur, ocol, col_after;
    logic [ROW_CNT_W-1:0] r_cur, orow, row_after;
    logic [WID_W-1:0]     col_inc;
    logic [CNT_W-1:0]     emit_inc;
    logic [CNT_W:0]       frame_size;
    meta_t                meta_in;

    assign en    = s_tready;
    assign s_acc = s_tvalid && s_tready;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WID_W'(1);
        end else if (image_width_reg > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        h_eff      = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
        wrap0      = {1'b0, in_col_reg} >= w_eff;
        c_cur      = wrap0 ? '0 : in_col_reg;
        r_cur      = wrap0 ? in_row_reg + ROW_CNT_W'(1) : in_row_reg;
        ignore     = s_tuser && (r_cur < {1'b0, h_eff});
        started    = (r_cur >= ROW_CNT_W'(2)) || ((r_cur == ROW_CNT_W'(1)) && (c_cur != '0));
        at_edge    = c_cur == '0;
        orow       = at_edge ? r_cur - ROW_CNT_W'(2) : r_cur - ROW_CNT_W'(1);
        ocol       = at_edge ? COL_W'(w_eff - WID_W'(1)) : c_cur - COL_W'(1);
        col_inc    = {1'b0, c_cur} + WID_W'(1);
        wrap1      = col_inc >= w_eff;
        col_after  = wrap1 ? '0 : col_inc[COL_W-1:0];
        row_after  = wrap1 ? r_cur + ROW_CNT_W'(1) : r_cur;
        emit_inc   = emitted_reg + CNT_W'(1);
        frame_size = (CNT_W+1)'(h_eff) * (CNT_W+1)'(w_eff);
        last       = started && ({1'b0, emit_inc} >= frame_size);

        meta_in.emit      = started;
        meta_in.last      = last;
        meta_in.right_rep = at_edge;
        meta_in.left_rep  = at_edge ? (w_eff < WID_W'(2)) : (c_cur == COL_W'(1));
        meta_in.top       = orow == '0;
        meta_in.bot       = ({1'b0, orow} + (ROW_CNT_W+1)'(1)) >= (ROW_CNT_W+1)'(h_eff);
        meta_in.col       = ocol;
        meta_in.row       = orow[ROW_W-1:0];

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        emitted_next = emitted_reg;
        if (s_acc) begin
            if (ignore) begin
                in_col_next = c_cur;
                in_row_next = r_cur;
            end else if (last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                emitted_next = '0;
            end else begin
                in_col_next  = col_after;
                in_row_next  = row_after;
                emitted_next = started ? emit_inc : emitted_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            emitted_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            emitted_reg <= emitted_next;
        end
    end

    // stage a: line store read
    logic                 a_valid_reg;
    meta_t                a_meta_reg;
    pixel_t               a_px_reg;
    logic [COL_W-1:0]     a_col_reg;
    pixel_t               rd_up_reg, rd_lo_reg;
    logic                 byp_reg;
    pixel_t               byp_up_reg, byp_lo_reg;
    pixel_t               a_up, a_lo;
    logic                 mem_wr;

    pixel_t mem_up [MAX_WIDTH];
    pixel_t mem_lo [MAX_WIDTH];

    assign a_up   = byp_reg ? byp_up_reg : rd_up_reg;
    assign a_lo   = byp_reg ? byp_lo_reg : rd_lo_reg;
    assign mem_wr = en && a_valid_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem_up[a_col_reg] <= a_lo;
            mem_lo[a_col_reg] <= a_px_reg;
        end
        if (s_acc) begin
            rd_up_reg <= mem_up[c_cur];
            rd_lo_reg <= mem_lo[c_cur];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            byp_up_reg <= a_lo;
            byp_lo_reg <= a_px_reg;
            a_meta_reg <= meta_in;
            a_px_reg   <= s_tdata;
            a_col_reg  <= c_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_acc && !ignore;
            if (s_acc) begin
                byp_reg <= mem_wr && (a_col_reg == c_cur);
            end
        end
    end

    // window and tap selection
    pixel_t win_reg [3][3];
    pixel_t col_new [3];
    pixel_t taps [3][3];

    assign col_new[0] = a_up;
    assign col_new[1] = a_lo;
    assign col_new[2] = a_px_reg;

    always_comb begin
        pixel_t mid [3];
        for (int r = 0; r < 3; r++) begin
            mid[r]     = win_reg[r][2];
            taps[r][1] = mid[r];
            taps[r][0] = a_meta_reg.left_rep ? mid[r] : win_reg[r][1];
            taps[r][2] = a_meta_reg.right_rep ? mid[r] : col_new[r];
        end
        if (a_meta_reg.top) begin
            for (int k = 0; k < 3; k++) begin
                taps[0][k] = taps[1][k];
            end
        end
        if (a_meta_reg.bot) begin
            for (int k = 0; k < 3; k++) begin
                taps[2][k] = taps[1][k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[r][k] <= '0;
                end
            end
        end else if (mem_wr) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
                win_reg[r][2] <= col_new[r];
            end
        end
    end

    // stage b: taps
    logic   b_valid_reg;
    meta_t  b_meta_reg;
    pixel_t b_taps_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            b_meta_reg <= a_meta_reg;
            b_taps_reg <= taps;
        end
    end

    // stage c: products
    logic                     c_valid_reg;
    meta_t                    c_meta_reg;
    logic signed [PROD_W-1:0] prod_reg [CHANNELS][3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            c_meta_reg <= b_meta_reg;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        prod_reg[ch][r][k] <=
                            $signed(PROD_W'({1'b0, b_taps_reg[r][k][ch*PIXEL_BITS +: PIXEL_BITS]}))
                            * PROD_W'($signed(coeff_reg[r][k*COEFF_BITS +: COEFF_BITS]));
                    end
                end
            end
        end
    end

    // stage d: row sums
    logic                    d_valid_reg;
    meta_t                   d_meta_reg;
    logic signed [ACC_W-1:0] row_sum_reg [CHANNELS][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            d_meta_reg <= c_meta_reg;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                for (int r = 0; r < 3; r++) begin
                    row_sum_reg[ch][r] <= ACC_W'(prod_reg[ch][r][0])
                        + ACC_W'(prod_reg[ch][r][1]) + ACC_W'(prod_reg[ch][r][2]);
                end
            end
        end
    end

    // stage e: channel sums
    logic                    e_valid_reg;
    meta_t                   e_meta_reg;
    logic signed [ACC_W-1:0] ch_sum_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (en) begin
            e_meta_reg <= d_meta_reg;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                ch_sum_reg[ch] <= row_sum_reg[ch][0] + row_sum_reg[ch][1] + row_sum_reg[ch][2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg && a_meta_reg.emit;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // result and output stage with skid entry
    result_t                 res;
    logic signed [ACC_W-1:0] total;

    always_comb begin
        total         = ch_sum_reg[0] + ch_sum_reg[1] + ch_sum_reg[2];
        res.frame_end = e_meta_reg.last;
        res.out_row   = e_meta_reg.row;
        res.out_col   = e_meta_reg.col;
        if (keep_reg) begin
            res.out0 = OUT0_W'(ch_sum_reg[0]);
            res.out1 = OUT12_W'(ch_sum_reg[1]);
            res.out2 = OUT12_W'(ch_sum_reg[2]);
        end else begin
            res.out0 = OUT0_W'(total);
            res.out1 = '0;
            res.out2 = '0;
        end
    end

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    out_free, incoming;

    assign out_free = !out_valid_reg || m_tready;
    assign incoming = en && e_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= skid_valid_reg || incoming;
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else if (incoming) begin
                    out_reg <= res;
                end
            end else if (incoming) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {1'b0, out_reg.out_row, out_reg.out_col,
                       out_reg.out2, out_reg.out1, out_reg.out0};

endmodule

/* rtl/wc3_checker.sv */
// ----------------------------------------------------------------------------
// wc3_checker
// port level checks of the 3x3 window convolution
// ----------------------------------------------------------------------------
module wc3_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [wc3_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import wc3_pkg::*;

    // a result transaction stalled keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // input back pressure only while a result waits
    a_ready_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // no result straight after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not cleared by reset");

    // back pressure clears once the waiting result is taken
    a_ready_return: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("input stall held after result taken");

    // padding bit of the result stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[OUT_TDATA_W-1])
        else $error("result padding bit set");

endmodule

bind window_convolution_3x3 wc3_checker u_wc3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
